// ===== src/rvex_pkg.sv =====
// Shared types, constants and operation codes for the RV64I execute unit.
package rvex_pkg;

    localparam int XLEN     = 64;
    localparam int NUM_REGS = 32;
    localparam int REG_IW   = $clog2(NUM_REGS);
    localparam int SH_W     = (XLEN > 32) ? 6 : 5;
    localparam int QDEPTH   = 2;

    // Operation codes.
    localparam logic [4:0] F_ADD   = 5'd0;
    localparam logic [4:0] F_SLT   = 5'd1;
    localparam logic [4:0] F_SLTU  = 5'd2;
    localparam logic [4:0] F_AND   = 5'd3;
    localparam logic [4:0] F_OR    = 5'd4;
    localparam logic [4:0] F_XOR   = 5'd5;
    localparam logic [4:0] F_SLL   = 5'd6;
    localparam logic [4:0] F_SRL   = 5'd7;
    localparam logic [4:0] F_SUB   = 5'd8;
    localparam logic [4:0] F_SRA   = 5'd9;
    localparam logic [4:0] F_ADDI  = 5'd10;
    localparam logic [4:0] F_SLTI  = 5'd11;
    localparam logic [4:0] F_SLTIU = 5'd12;
    localparam logic [4:0] F_ANDI  = 5'd13;
    localparam logic [4:0] F_ORI   = 5'd14;
    localparam logic [4:0] F_XORI  = 5'd15;
    localparam logic [4:0] F_SLLI  = 5'd16;
    localparam logic [4:0] F_SRLI  = 5'd17;
    localparam logic [4:0] F_SRAI  = 5'd18;
    localparam logic [4:0] F_BEQ   = 5'd19;
    localparam logic [4:0] F_BNE   = 5'd20;
    localparam logic [4:0] F_BLT   = 5'd21;
    localparam logic [4:0] F_BLTU  = 5'd22;
    localparam logic [4:0] F_BGE   = 5'd23;
    localparam logic [4:0] F_BGEU  = 5'd24;
    localparam logic [4:0] F_LUI   = 5'd25;
    localparam logic [4:0] F_AUIPC = 5'd26;
    localparam logic [4:0] F_JAL   = 5'd27;
    localparam logic [4:0] F_JALR  = 5'd28;

    // Instruction class decided by the front end.
    typedef enum logic [2:0] {
        C_NOP, C_ALU, C_BRANCH, C_LUI, C_AUIPC, C_JAL, C_JALR
    } t_class;

    // ALU operations.
    typedef enum logic [3:0] {
        A_ADD, A_SLT, A_SLTU, A_AND, A_OR, A_XOR, A_SLL, A_SRL, A_SUB, A_SRA
    } t_aluop;

    // Branch conditions.
    typedef enum logic [2:0] {
        B_EQ, B_NE, B_LT, B_LTU, B_GE, B_GEU
    } t_brop;

    // One classified instruction as it travels through the queue.
    typedef struct packed {
        t_class           cls;
        t_aluop           aluop;
        t_brop            brop;
        logic             use_imm;
        logic [4:0]       rs1;
        logic [4:0]       rs2;
        logic [4:0]       rd;
        logic [XLEN-1:0]  imm;
    } t_uop;

endpackage

// ===== src/rvex_front.sv =====
// Front end: accepts instruction beats, classifies them and queues them.
module rvex_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [4:0]             i_func,
    input  logic [4:0]             i_rs1_index,
    input  logic [4:0]             i_rs2_index,
    input  logic [4:0]             i_rd_index,
    input  logic [63:0]            i_immediate,
    output logic                   o_uop_valid,
    output rvex_pkg::t_uop         o_uop,
    input  logic                   i_uop_take
);
    import rvex_pkg::*;

    localparam int QW = $clog2(QDEPTH);

    t_uop            r_q [QDEPTH];
    logic [QW-1:0]   r_wp, r_rp;
    logic [QW:0]     r_cnt;
    t_uop            n_uop;
    logic            push;

    // Decode the operation code into a class and a sub-operation.
    always_comb begin
        n_uop         = '0;
        n_uop.cls     = C_NOP;
        n_uop.aluop   = A_ADD;
        n_uop.brop    = B_EQ;
        n_uop.rs1     = i_rs1_index;
        n_uop.rs2     = i_rs2_index;
        n_uop.rd      = i_rd_index;
        n_uop.imm     = i_immediate[XLEN-1:0];
        case (i_func)
            F_ADD:   begin n_uop.cls = C_ALU; n_uop.aluop = A_ADD;  end
            F_SLT:   begin n_uop.cls = C_ALU; n_uop.aluop = A_SLT;  end
            F_SLTU:  begin n_uop.cls = C_ALU; n_uop.aluop = A_SLTU; end
            F_AND:   begin n_uop.cls = C_ALU; n_uop.aluop = A_AND;  end
            F_OR:    begin n_uop.cls = C_ALU; n_uop.aluop = A_OR;   end
            F_XOR:   begin n_uop.cls = C_ALU; n_uop.aluop = A_XOR;  end
            F_SLL:   begin n_uop.cls = C_ALU; n_uop.aluop = A_SLL;  end
            F_SRL:   begin n_uop.cls = C_ALU; n_uop.aluop = A_SRL;  end
            F_SUB:   begin n_uop.cls = C_ALU; n_uop.aluop = A_SUB;  end
            F_SRA:   begin n_uop.cls = C_ALU; n_uop.aluop = A_SRA;  end
            F_ADDI:  begin n_uop.cls = C_ALU; n_uop.aluop = A_ADD;  n_uop.use_imm = 1'b1; end
            F_SLTI:  begin n_uop.cls = C_ALU; n_uop.aluop = A_SLT;  n_uop.use_imm = 1'b1; end
            F_SLTIU: begin n_uop.cls = C_ALU; n_uop.aluop = A_SLTU; n_uop.use_imm = 1'b1; end
            F_ANDI:  begin n_uop.cls = C_ALU; n_uop.aluop = A_AND;  n_uop.use_imm = 1'b1; end
            F_ORI:   begin n_uop.cls = C_ALU; n_uop.aluop = A_OR;   n_uop.use_imm = 1'b1; end
            F_XORI:  begin n_uop.cls = C_ALU; n_uop.aluop = A_XOR;  n_uop.use_imm = 1'b1; end
            F_SLLI:  begin n_uop.cls = C_ALU; n_uop.aluop = A_SLL;  n_uop.use_imm = 1'b1; end
            F_SRLI:  begin n_uop.cls = C_ALU; n_uop.aluop = A_SRL;  n_uop.use_imm = 1'b1; end
            F_SRAI:  begin n_uop.cls = C_ALU; n_uop.aluop = A_SRA;  n_uop.use_imm = 1'b1; end
            F_BEQ:   begin n_uop.cls = C_BRANCH; n_uop.brop = B_EQ;  end
            F_BNE:   begin n_uop.cls = C_BRANCH; n_uop.brop = B_NE;  end
            F_BLT:   begin n_uop.cls = C_BRANCH; n_uop.brop = B_LT;  end
            F_BLTU:  begin n_uop.cls = C_BRANCH; n_uop.brop = B_LTU; end
            F_BGE:   begin n_uop.cls = C_BRANCH; n_uop.brop = B_GE;  end
            F_BGEU:  begin n_uop.cls = C_BRANCH; n_uop.brop = B_GEU; end
            F_LUI:   n_uop.cls = C_LUI;
            F_AUIPC: n_uop.cls = C_AUIPC;
            F_JAL:   n_uop.cls = C_JAL;
            F_JALR:  n_uop.cls = C_JALR;
            default: n_uop.cls = C_NOP;
        endcase
    end

    assign o_stall     = (r_cnt == QDEPTH[QW:0]);
    assign push        = i_valid && !o_stall;
    assign o_uop_valid = (r_cnt != '0);
    assign o_uop       = r_q[r_rp];

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_uop_take) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {{QW{1'b0}}, push} - {{QW{1'b0}}, i_uop_take};
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_uop;
    end

endmodule

// ===== src/rvex_back.sv =====
// Back end: register file, program counter, ALU and branch logic, result register.
module rvex_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [63:0]            i_cfg_data,
    input  logic                   i_uop_valid,
    input  rvex_pkg::t_uop         i_uop,
    output logic                   o_uop_take,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [63:0]            o_rd_value,
    output logic                   o_rd_written,
    output logic [63:0]            o_next_pc,
    output logic                   o_branch_taken
);
    import rvex_pkg::*;

    logic [XLEN-1:0] r_rf [NUM_REGS];
    logic [XLEN-1:0] r_pc;
    logic            r_valid;
    logic [XLEN-1:0] r_val, r_npc;
    logic            r_wr, r_taken;

    logic [XLEN-1:0] a, b, opb, alu, seq, pc_imm, val, npc;
    logic [SH_W-1:0] sh;
    logic            lts, ltu, eq, cond, wr, taken;
    logic [REG_IW:0] rd_w;

    // Register reads; entries past the file and x0 read as zero.
    always_comb begin
        a = '0;
        b = '0;
        if (i_uop.rs1 != '0 && {1'b0, i_uop.rs1} < 6'(NUM_REGS))
            a = r_rf[i_uop.rs1[REG_IW-1:0]];
        if (i_uop.rs2 != '0 && {1'b0, i_uop.rs2} < 6'(NUM_REGS))
            b = r_rf[i_uop.rs2[REG_IW-1:0]];
    end

    assign opb = i_uop.use_imm ? i_uop.imm : b;
    assign sh  = opb[SH_W-1:0];
    assign ltu = a < opb;
    assign lts = (a ^ {1'b1, {(XLEN-1){1'b0}}}) < (opb ^ {1'b1, {(XLEN-1){1'b0}}});
    assign eq  = (a == b);

    // ALU.
    always_comb begin
        case (i_uop.aluop)
            A_ADD:   alu = a + opb;
            A_SUB:   alu = a - opb;
            A_SLT:   alu = {{(XLEN-1){1'b0}}, lts};
            A_SLTU:  alu = {{(XLEN-1){1'b0}}, ltu};
            A_AND:   alu = a & opb;
            A_OR:    alu = a | opb;
            A_XOR:   alu = a ^ opb;
            A_SLL:   alu = ({1'b0, sh} < (SH_W+1)'(XLEN)) ? a << sh : '0;
            A_SRL:   alu = ({1'b0, sh} < (SH_W+1)'(XLEN)) ? a >> sh : '0;
            A_SRA:   alu = $signed(a) >>> sh;
            default: alu = '0;
        endcase
    end

    // Branch condition.
    always_comb begin
        case (i_uop.brop)
            B_EQ:    cond = eq;
            B_NE:    cond = !eq;
            B_LT:    cond = lts;
            B_LTU:   cond = ltu;
            B_GE:    cond = !lts;
            B_GEU:   cond = !ltu;
            default: cond = 1'b0;
        endcase
    end

    assign seq    = r_pc + XLEN'(4);
    assign pc_imm = r_pc + i_uop.imm;

    // Result selection per class.
    always_comb begin
        val   = '0;
        wr    = 1'b0;
        taken = 1'b0;
        npc   = seq;
        case (i_uop.cls)
            C_ALU:    begin val = alu; wr = 1'b1; end
            C_BRANCH: begin
                if (cond) begin
                    taken = 1'b1;
                    npc   = pc_imm;
                end
            end
            C_LUI:    begin val = i_uop.imm; wr = 1'b1; end
            C_AUIPC:  begin val = pc_imm; wr = 1'b1; end
            C_JAL:    begin val = seq; wr = 1'b1; taken = 1'b1; npc = pc_imm; end
            C_JALR:   begin
                val   = seq;
                wr    = 1'b1;
                taken = 1'b1;
                npc   = (a + i_uop.imm) & ~XLEN'(1);
            end
            default:  ;
        endcase
        rd_w = {1'b0, i_uop.rd[REG_IW-1:0]};
        if (i_uop.rd == '0 || {1'b0, i_uop.rd} >= 6'(NUM_REGS)) wr = 1'b0;
        if (!wr) val = '0;
    end

    assign o_uop_take = i_uop_valid && (!r_valid || !i_stall);

    // Program counter, result register and valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_pc <= i_cfg_data[XLEN-1:0];
            else if (o_uop_take) r_pc <= npc;
            if (o_uop_take) r_valid <= 1'b1;
            else if (!i_stall) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_uop_take) begin
            r_val   <= val;
            r_wr    <= wr;
            r_npc   <= npc;
            r_taken <= taken;
        end
    end

    // Register file: cleared by reset, written at retire.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) r_rf[k] <= '0;
        end else if (o_uop_take && wr) begin
            r_rf[rd_w[REG_IW-1:0]] <= val;
        end
    end

    assign o_valid        = r_valid;
    assign o_rd_value     = 64'(r_val);
    assign o_rd_written   = r_wr;
    assign o_next_pc      = 64'(r_npc);
    assign o_branch_taken = r_taken;

endmodule

// ===== src/rv64i_integer_execute_unit_core.sv =====
// Top level of the RV64I integer execute unit.
// Executes one decoded RV64I integer instruction per beat: ALU, branches, lui, auipc,
// jal and jalr, on a 32 x 64 register file (x0 reads zero) and a program counter. A
// beat enters a two-entry classification queue, then executes and retires into an
// output result register; sustained rate is one instruction per cycle while i_stall
// is low, and input beats fill the queue while a result waits. Each instruction reads
// its operands from the register file as of the previous retirement. Writing
// start_address loads the pc at once; configure only while the unit is idle.
module rv64i_integer_execute_unit_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [4:0]  i_func,
    input  logic [4:0]  i_rs1_index,
    input  logic [4:0]  i_rs2_index,
    input  logic [4:0]  i_rd_index,
    input  logic [63:0] i_immediate,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_rd_value,
    output logic        o_rd_written,
    output logic [63:0] o_next_pc,
    output logic        o_branch_taken
);
    import rvex_pkg::*;

    logic uop_valid, uop_take;
    t_uop uop;

    assign o_cfg_ready = 1'b1;

    rvex_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_func, .i_rs1_index,
        .i_rs2_index, .i_rd_index, .i_immediate,
        .o_uop_valid(uop_valid), .o_uop(uop), .i_uop_take(uop_take)
    );

    rvex_back u_back (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_data,
        .i_uop_valid(uop_valid), .i_uop(uop), .o_uop_take(uop_take),
        .o_valid, .i_stall, .o_rd_value, .o_rd_written, .o_next_pc, .o_branch_taken
    );

endmodule
